[rtl/efla_pkg.sv]
// ----------------------------------------------------------------------------
// efla_pkg
// shared types and constants of the exact-fit free-list allocator
// ----------------------------------------------------------------------------
package efla_pkg;

	localparam int unsigned HEAP_BYTES   = 65536;
	localparam int unsigned FREE_SLOTS   = 64;
	localparam int unsigned HEADER_BYTES = 16;

	localparam int unsigned HDR_DEPTH = HEAP_BYTES / 8;
	localparam int unsigned HDR_AW    = $clog2(HDR_DEPTH);
	localparam int unsigned FT_AW     = $clog2(FREE_SLOTS);
	localparam int unsigned CNT_W     = FT_AW + 1;

	localparam int unsigned OFF_W  = 16;
	localparam int unsigned SIZE_W = 17;
	localparam int unsigned SZ_W   = SIZE_W + 1;
	localparam int unsigned ALU_W  = SIZE_W + 2;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [SIZE_W-1:0] req_size;
		logic [OFF_W-1:0]  free_offset;
	} in_item_t;

	typedef struct packed {
		logic [OFF_W-1:0] block_offset;
		logic             ok;
		logic             from_free_list;
	} out_item_t;

	typedef struct packed {
		logic [OFF_W-1:0]  offset;
		logic [SIZE_W-1:0] size;
	} table_entry_t;

endpackage

[rtl/exact_fit_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// exact_fit_free_list_allocator_unit
// heap allocator over byte offsets: exact-fit reuse from a lifo free table,
// else bump allocation with a size header
// ----------------------------------------------------------------------------
//
//  channel | signals                         | direction | carries
//  --------+---------------------------------+-----------+------------------------
//  in      | in_valid in_ready in_data       | into      | op, req_size, free_offset
//  out     | out_valid out_ready out_data    | out of    | block_offset, ok, from_free_list
//  cfg     | cfg_valid cfg_ready cfg_data    | into      | heap_size
//
//  an allocate rounds its size up to a multiple of 8 bytes and is refused when
//  oversized; it then probes the free table newest entry first for an exact size
//  match and on a hit moves the entries above the reused one down, else bump
//  allocates; a free is refused below a header or on a full table; reinit empties
//  the heap and the table; the free table port reads one entry per cycle
//  reset clears control state only; both memories start undefined
//  in_ready is high only while the sequencer is idle; a finished item waits
//  in the output register while the next item is already being worked on
//
module exact_fit_free_list_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  efla_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output efla_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [efla_pkg::SIZE_W-1:0] cfg_data
);

	import efla_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROUND = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SRCH  = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_B1    = 4'd5;
	localparam logic [3:0] S_B2    = 4'd6;
	localparam logic [3:0] S_B3    = 4'd7;
	localparam logic [3:0] S_FCHK  = 4'd8;
	localparam logic [3:0] S_FWR   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;        // free table fill count
	logic [SIZE_W-1:0] top_q;        // bump pointer
	logic [SIZE_W-1:0] heap_q;       // effective heap size, already clamped
	logic              out_valid_q;
	out_item_t         out_q;

	// item being worked on and working registers
	in_item_t          item_q;
	out_item_t         res_q;
	logic [SZ_W-1:0]   size_q;       // rounded request
	logic [ALU_W-1:0]  boff_q;       // top + header, payload offset of a bump
	logic [ALU_W-1:0]  end_q;        // new top after a bump
	logic [CNT_W-1:0]  sp_q;         // search: entries still to probe
	logic [CNT_W-1:0]  rp_q;         // compaction: next entry to read
	logic              v_s1;         // table read in flight
	logic [FT_AW-1:0]  idx_s1;       // index that goes with the read in flight

	// shared unit
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic              alu_sub;
	logic [ALU_W-1:0]  alu_res;
	logic              alu_lt;
	logic              alu_eq;

	// free table and header store ports
	logic              t_we;
	logic [FT_AW-1:0]  t_waddr;
	table_entry_t      t_wdata;
	logic [FT_AW-1:0]  t_raddr;
	table_entry_t      t_rdata;
	logic              h_we;
	logic [HDR_AW-1:0] h_waddr;
	logic [SIZE_W-1:0] h_wdata;
	logic [HDR_AW-1:0] h_raddr;
	logic [SIZE_W-1:0] h_rdata;

	logic              accept;
	logic              found;
	logic              rp_lt_cnt;
	logic              cnt_full;
	logic              fin_go;
	logic [CNT_W-1:0]  sp_m1;
	logic [CNT_W-1:0]  rp_m1;
	logic [SIZE_W-1:0] cfg_eff;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign accept    = in_valid && in_ready;

	assign sp_m1     = sp_q - 1'b1;
	assign rp_m1     = rp_q - 1'b1;
	assign rp_lt_cnt = (rp_q < cnt_q);
	assign cnt_full  = (cnt_q >= CNT_W'(FREE_SLOTS));
	assign found     = (state_q == S_SRCH) && v_s1 && alu_eq;
	assign fin_go    = !out_valid_q || out_ready;

	// heap sizes beyond the managed range are clamped once, at the write
	assign cfg_eff = (cfg_data > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES) : cfg_data;

	// operand selection for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_ROUND: begin
				alu_a = ALU_W'(item_q.req_size);
				alu_b = ALU_W'(7);
			end
			S_CHK: begin
				// oversized request: heap < size
				alu_a = ALU_W'(heap_q);
				alu_b = ALU_W'(size_q);
			end
			S_SRCH: begin
				alu_a = ALU_W'(t_rdata.size);
				alu_b = ALU_W'(size_q);
			end
			S_B1: begin
				alu_a = ALU_W'(top_q);
				alu_b = ALU_W'(HEADER_BYTES);
			end
			S_B2: begin
				alu_a = boff_q;
				alu_b = ALU_W'(size_q);
			end
			S_B3: begin
				// heap exhausted: heap < top + header + size
				alu_a = ALU_W'(heap_q);
				alu_b = end_q;
			end
			S_FCHK: begin
				// header address of the freed block, borrow means below header
				alu_a   = ALU_W'(item_q.free_offset);
				alu_b   = ALU_W'(HEADER_BYTES);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	efla_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.lt  (alu_lt),
		.eq  (alu_eq)
	);

	// memory port selection
	always_comb begin
		t_we    = 1'b0;
		t_waddr = idx_s1;
		t_wdata = t_rdata;
		t_raddr = '0;
		h_we    = 1'b0;
		h_waddr = top_q[3 +: HDR_AW];
		h_wdata = size_q[SIZE_W-1:0];
		h_raddr = alu_res[3 +: HDR_AW];
		unique case (state_q)
			S_SRCH: begin
				t_raddr = sp_m1[FT_AW-1:0];
			end
			S_SHIFT: begin
				// entries above the reused one move down by one
				t_raddr = rp_q[FT_AW-1:0];
				t_we    = v_s1;
			end
			S_FWR: begin
				t_we           = 1'b1;
				t_waddr        = cnt_q[FT_AW-1:0];
				t_wdata.offset = item_q.free_offset;
				t_wdata.size   = h_rdata;
			end
			S_B3: begin
				h_we = !alu_lt;
			end
			default: begin
				t_raddr = '0;
			end
		endcase
	end

	efla_ram #(
		.WIDTH ($bits(table_entry_t)),
		.DEPTH (FREE_SLOTS)
	) u_free_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	efla_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (HDR_DEPTH)
	) u_hdr_store (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			top_q       <= '0;
			heap_q      <= SIZE_W'(HEAP_BYTES);
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				heap_q <= cfg_eff;
			end
			// a finished item refills the output register as it drains
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.op)
							OP_ALLOC: state_q <= S_ROUND;
							OP_FREE:  state_q <= S_FCHK;
							OP_INIT: begin
								top_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_FIN;
							end
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_ROUND: state_q <= S_CHK;
				S_CHK: begin
					v_s1    <= 1'b0;
					state_q <= alu_lt ? S_FIN : S_SRCH;
				end
				S_SRCH: begin
					v_s1 <= !found && (sp_q != '0);
					if (found) begin
						state_q <= S_SHIFT;
					end else if (!v_s1 && (sp_q == '0)) begin
						state_q <= S_B1;
					end
				end
				S_SHIFT: begin
					v_s1 <= rp_lt_cnt;
					if (!v_s1 && !rp_lt_cnt) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_FIN;
					end
				end
				S_B1: state_q <= S_B2;
				S_B2: state_q <= S_B3;
				S_B3: begin
					if (!alu_lt) begin
						top_q <= end_q[SIZE_W-1:0];
					end
					state_q <= S_FIN;
				end
				S_FCHK: begin
					state_q <= (alu_lt || cnt_full) ? S_FIN : S_FWR;
				end
				S_FWR: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= in_data;
					// reinit answers ok, everything else starts from zero
					res_q  <= {{OFF_W{1'b0}}, (in_data.op == OP_INIT), 1'b0};
				end
			end
			S_ROUND: begin
				size_q <= {alu_res[SZ_W-1:3], 3'b000};
			end
			S_CHK: begin
				sp_q <= cnt_q;
			end
			S_SRCH: begin
				if (found) begin
					res_q.block_offset   <= t_rdata.offset;
					res_q.ok             <= 1'b1;
					res_q.from_free_list <= 1'b1;
					rp_q                 <= CNT_W'(idx_s1) + 1'b1;
				end else if (sp_q != '0) begin
					sp_q   <= sp_m1;
					idx_s1 <= sp_m1[FT_AW-1:0];
				end
			end
			S_SHIFT: begin
				if (rp_lt_cnt) begin
					rp_q   <= rp_q + 1'b1;
					idx_s1 <= rp_m1[FT_AW-1:0];
				end
			end
			S_B1: begin
				boff_q <= alu_res;
			end
			S_B2: begin
				end_q <= alu_res;
			end
			S_B3: begin
				if (!alu_lt) begin
					res_q.block_offset <= boff_q[OFF_W-1:0];
					res_q.ok           <= 1'b1;
				end
			end
			S_FWR: begin
				res_q.ok <= 1'b1;
			end
			S_FIN: begin
				if (fin_go) begin
					out_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// fill count stays within the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FREE_SLOTS))
		else $error("free table fill count out of range");

	// bump pointer only ever moves in whole 8-byte units
	a_top_align: assert property (@(posedge clk) disable iff (!arst_n)
		top_q[2:0] == 3'b000)
		else $error("bump pointer misaligned");

	// table reads are only in flight during search or compaction
	a_rd_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_SRCH || state_q == S_SHIFT))
		else $error("table read in flight outside search or compaction");

	// the table is written only while compacting or pushing a freed block
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> (state_q == S_SHIFT || state_q == S_FWR))
		else $error("free table written in wrong state");

	// fill count changes by one per item, or drops to empty on reinit
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			(cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1
			|| cnt_q == '0))
		else $error("free table fill count jumped");
`endif

endmodule

[rtl/efla_ram.sv]
// ----------------------------------------------------------------------------
// efla_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module efla_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/efla_alu.sv]
// ----------------------------------------------------------------------------
// efla_alu
// shared add/subtract and magnitude compare unit of the sequencer
// ----------------------------------------------------------------------------
module efla_alu (
	input  logic [efla_pkg::ALU_W-1:0] a,
	input  logic [efla_pkg::ALU_W-1:0] b,
	input  logic                       sub,
	output logic [efla_pkg::ALU_W-1:0] res,
	output logic                       lt,
	output logic                       eq
);

	import efla_pkg::*;

	always_comb begin
		res = sub ? (a - b) : (a + b);
		lt  = (a < b);
		eq  = (a == b);
	end

endmodule
